/* rtl/ipv4_longest_prefix_match_table_macros.svh */
// Assertion macros for the forwarding table sequencer.
`ifndef IPV4_LONGEST_PREFIX_MATCH_TABLE_MACROS_SVH
`define IPV4_LONGEST_PREFIX_MATCH_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define LPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpm assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define LPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpm assertion failed");

`endif

/* rtl/lpm_pkg.sv */
// Types, codes and constants of the IPv4 forwarding table.
`timescale 1ns / 1ps

package lpm_pkg;

  localparam int ADDR_W              = 32;
  localparam int LEN_W               = 6;
  localparam int PORT_W              = 8;
  localparam int DEFAULT_TABLE_DEPTH = 64;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADLEN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [PORT_W-1:0] port;
  } entry_t;

  // Sequencer to match unit: start of a lookup, and read data valid.
  typedef struct packed {
    logic start;
    logic rvalid;
  } scan_ctl_t;

endpackage

/* rtl/lpm_req_if.sv */
// Request channel of the forwarding table.
`timescale 1ns / 1ps

interface lpm_req_if import lpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0]  prefix_len;
  logic [PORT_W-1:0] port_in;

  modport source (output valid, op, addr, prefix_len, port_in, input ready);
  modport sink (input valid, op, addr, prefix_len, port_in, output ready);
endinterface

/* rtl/lpm_rsp_if.sv */
// Response channel of the forwarding table.
`timescale 1ns / 1ps

interface lpm_rsp_if import lpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              found;
  logic [PORT_W-1:0] out_port;

  modport source (output valid, status, found, out_port, input ready);
  modport sink (input valid, status, found, out_port, output ready);
endinterface

/* rtl/lpm_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/lpm_match.sv */
// Shared masked compare unit that keeps the best match of a lookup.
`timescale 1ns / 1ps

module lpm_match import lpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  scan_ctl_t         ctl,
  input  logic [ADDR_W-1:0] key_in,
  input  entry_t            entry,
  output logic              hit,
  output logic [PORT_W-1:0] port
);

  logic [ADDR_W-1:0] key;
  logic [LEN_W-1:0]  best_len;
  logic [ADDR_W-1:0] mask;
  logic              match;
  logic              better;

  // A zero length masks every bit, so the prefix matches any address.
  always_comb begin
    if (entry.len == '0) begin
      mask = '0;
    end else begin
      mask = {ADDR_W{1'b1}} << (LEN_W'(ADDR_W) - entry.len);
    end
    match  = ((key ^ entry.addr) & mask) == '0;
    // Strict compare in oldest-first order keeps the oldest of equal lengths.
    better = match && (!hit || (entry.len > best_len));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.start) begin
      hit <= 1'b0;
    end else if (ctl.rvalid && better) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      key      <= key_in;
      best_len <= '0;
      port     <= '0;
    end else if (ctl.rvalid && better) begin
      best_len <= entry.len;
      port     <= entry.port;
    end
  end

endmodule

/* rtl/lpm_ctrl.sv */
// Sequencer: request decode, table fill count, entry scan and result register.
`timescale 1ns / 1ps
`include "ipv4_longest_prefix_match_table_macros.svh"

module lpm_ctrl import lpm_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  lpm_req_if.sink           req,
  lpm_rsp_if.source         rsp,
  output logic              ram_we,
  output logic              ram_re,
  output logic [AW-1:0]     ram_addr,
  output entry_t            ram_wdata,
  output scan_ctl_t         scan,
  input  logic              match_hit,
  input  logic [PORT_W-1:0] match_port
);

  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          rvalid;
  status_e       res_status;
  logic          res_lookup;
  logic          accept;
  logic          load_out;
  logic          out_valid;
  logic [1:0]    out_status;
  logic          out_found;
  logic [PORT_W-1:0] out_port;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.op == OP_LOOKUP) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (!rvalid && (idx == count)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = (state == S_IDLE);
    accept      = req.valid && (state == S_IDLE);
    ram_we      = accept && (req.op == OP_ADD) && (req.prefix_len <= MAX_LEN)
                  && (count < DEPTH_C);
    ram_re      = (state == S_SCAN) && (idx < count);
    ram_addr    = (state == S_SCAN) ? idx[AW-1:0] : count[AW-1:0];
    ram_wdata   = '{addr: req.addr, len: req.prefix_len, port: req.port_in};
    scan.start  = accept && (req.op == OP_LOOKUP);
    scan.rvalid = rvalid;
    load_out    = (state == S_DONE) && (!out_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= ram_re;
      if (ram_we) begin
        count <= count + 1'b1;
      end else if (accept && (req.op == OP_CLEAR)) begin
        count <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx        <= '0;
      res_lookup <= (req.op == OP_LOOKUP);
      if (req.op != OP_ADD) begin
        res_status <= ST_DONE;
      end else if (req.prefix_len > MAX_LEN) begin
        res_status <= ST_BADLEN;
      end else if (count >= DEPTH_C) begin
        res_status <= ST_FULL;
      end else begin
        res_status <= ST_DONE;
      end
    end else if (ram_re) begin
      idx <= idx + 1'b1;
    end
    if (load_out) begin
      out_status <= res_status;
      out_found  <= res_lookup && match_hit;
      out_port   <= res_lookup ? match_port : '0;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.found    = out_found;
  assign rsp.out_port = out_port;

  `LPM_ASSERT_NOW(a_count_bound, 1'b1, count <= DEPTH_C)
  `LPM_ASSERT_NOW(a_scan_index, state == S_SCAN, idx <= count)
  `LPM_ASSERT_NEXT(a_lookup_scans, scan.start, state == S_SCAN)
  `LPM_ASSERT_NEXT(a_add_grows, ram_we, count == $past(count) + 1'b1)

endmodule

/* rtl/ipv4_longest_prefix_match_table.sv */
// Top level of the IPv4 longest-prefix-match forwarding table.
`timescale 1ns / 1ps

// Each request carries an op: add appends a prefix (address, length, port),
// clear empties the table, lookup returns the port of the longest stored prefix
// that matches the address, the oldest entry winning among equal lengths. Every
// request gives exactly one response. Entries sit in a single-port RAM that is
// read one entry per cycle, and one masked compare unit walks them in order, so
// the stored entry count sets the time of a lookup. The response sits in an
// output register, so the next request is taken while a result still waits
// there; the result after it is held back until the waiting one has been taken.
module ipv4_longest_prefix_match_table import lpm_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  lpm_req_if.sink   req,
  lpm_rsp_if.source rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_addr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  scan_ctl_t         scan;
  logic              match_hit;
  logic [PORT_W-1:0] match_port;

  lpm_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .ram_we     (ram_we),
    .ram_re     (ram_re),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .scan       (scan),
    .match_hit  (match_hit),
    .match_port (match_port)
  );

  lpm_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  lpm_match u_match (
    .clk    (clk),
    .rst    (rst),
    .ctl    (scan),
    .key_in (req.addr),
    .entry  (ram_rdata),
    .hit    (match_hit),
    .port   (match_port)
  );

endmodule

/* tb/sv/tb_ipv4_longest_prefix_match_table.sv */
// Self-checking testbench for the IPv4 longest-prefix-match forwarding table.
`timescale 1ns / 1ps

module tb_ipv4_longest_prefix_match_table;
  import lpm_pkg::*;

  localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [PORT_W-1:0] port;
    bit                drain;
  } route_req_t;

  typedef struct {
    logic [1:0]        status;
    logic              found;
    logic [PORT_W-1:0] port;
  } route_rsp_t;

  logic clk = 1'b0;
  logic rst;

  lpm_req_if req_bus ();
  lpm_rsp_if rsp_bus ();

  ipv4_longest_prefix_match_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #6 clk = ~clk;

  // Shadow copy of the forwarding table.
  logic [ADDR_W-1:0] fib_addr [TABLE_DEPTH];
  logic [LEN_W-1:0]  fib_len  [TABLE_DEPTH];
  logic [PORT_W-1:0] fib_port [TABLE_DEPTH];
  int                fib_count = 0;

  route_req_t  request_q [$];
  route_rsp_t  answer_q [$];
  route_req_t  cur_req;
  route_req_t  seen_req;
  route_rsp_t  want;
  logic        req_fire = 1'b0;
  int unsigned sent = 0;
  int unsigned total_reqs = 0;
  int unsigned rsp_count = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  function automatic logic [ADDR_W-1:0] len_mask(logic [LEN_W-1:0] len);
    if (len == 0) return '0;
    if (len > MAX_LEN) return '1;
    return {ADDR_W{1'b1}} << (ADDR_W - len);
  endfunction

  // Applies one request to the shadow table and returns the response it should give.
  function automatic route_rsp_t fib_apply(route_req_t r);
    route_rsp_t res;
    bit hit;
    int best;
    logic [ADDR_W-1:0] m;
    res.status = ST_DONE;
    res.found = 1'b0;
    res.port = '0;
    case (r.op)
      OP_ADD: begin
        if (r.len > MAX_LEN) begin
          res.status = ST_BADLEN;
        end else if (fib_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          fib_addr[fib_count] = r.addr;
          fib_len[fib_count] = r.len;
          fib_port[fib_count] = r.port;
          fib_count++;
        end
      end
      OP_CLEAR: begin
        fib_count = 0;
      end
      OP_LOOKUP: begin
        hit = 1'b0;
        best = 0;
        // Oldest first with a strict compare, so the oldest entry wins a tie.
        for (int i = 0; i < fib_count; i++) begin
          m = len_mask(fib_len[i]);
          if (((r.addr ^ fib_addr[i]) & m) == '0 && (!hit || int'(fib_len[i]) > best)) begin
            hit = 1'b1;
            best = int'(fib_len[i]);
            res.port = fib_port[i];
          end
        end
        res.found = hit;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    errors++;
    $display("response %0d: %s is %0h, expected %0h", rsp_count, what, got, exp_val);
  endtask

  task automatic queue_req(logic [1:0] op, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                           logic [PORT_W-1:0] port, bit drain);
    route_req_t r;
    r.op = op;
    r.addr = addr;
    r.len = len;
    r.port = port;
    r.drain = drain;
    request_q.push_back(r);
  endtask

  // Episodes of clear, adds around a few shared bases, and lookups near stored prefixes.
  task automatic build_random_traffic();
    logic [ADDR_W-1:0] base [4];
    logic [ADDR_W-1:0] seen_addr [$];
    logic [LEN_W-1:0]  seen_len [$];
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] m;
    logic [LEN_W-1:0]  l;
    int fill_goal;
    int probe_goal;
    int adds;
    int probes;
    int k;
    int made;
    made = 0;
    while (made < RANDOM_ITEMS) begin
      for (k = 0; k < 4; k++) base[k] = $urandom();
      seen_addr.delete();
      seen_len.delete();
      queue_req(OP_CLEAR, $urandom(), LEN_W'($urandom_range(0, 63)),
                PORT_W'($urandom_range(0, 255)), 1'b0);
      made++;
      fill_goal = ($urandom_range(0, 3) == 0) ? TABLE_DEPTH + $urandom_range(1, 4)
                                               : $urandom_range(0, 24);
      probe_goal = $urandom_range(5, 30);
      adds = 0;
      probes = 0;
      while (adds < fill_goal || probes < probe_goal) begin
        if (adds < fill_goal && (probes >= probe_goal || $urandom_range(0, 1) == 0)) begin
          if (seen_addr.size() != 0 && $urandom_range(0, 7) == 0) begin
            // Same prefix again, usually with another port.
            k = $urandom_range(0, seen_addr.size() - 1);
            a = seen_addr[k];
            l = seen_len[k];
          end else begin
            a = base[$urandom_range(0, 3)] ^ ($urandom() >> $urandom_range(0, 32));
            case ($urandom_range(0, 7))
              0: l = '0;
              1: l = MAX_LEN;
              default: l = LEN_W'($urandom_range(1, 32));
            endcase
          end
          seen_addr.push_back(a);
          seen_len.push_back(l);
          queue_req(OP_ADD, a, l, PORT_W'($urandom_range(0, 255)), $urandom_range(0, 99) == 0);
          adds++;
        end else begin
          if (seen_addr.size() != 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, seen_addr.size() - 1);
            m = len_mask(seen_len[k]);
            a = (seen_addr[k] & m) | ($urandom() & ~m);
          end else if ($urandom_range(0, 1) == 0) begin
            a = base[$urandom_range(0, 3)] ^ ($urandom() >> $urandom_range(0, 32));
          end else begin
            a = $urandom();
          end
          queue_req(OP_LOOKUP, a, LEN_W'($urandom_range(0, 63)),
                    PORT_W'($urandom_range(0, 255)), $urandom_range(0, 99) == 0);
          probes++;
        end
        made++;
        if ($urandom_range(0, 24) == 0) begin
          if ($urandom_range(0, 1) == 0)
            queue_req(OP_UNUSED, $urandom(), LEN_W'($urandom_range(0, 63)),
                      PORT_W'($urandom_range(0, 255)), 1'b0);
          else
            queue_req(OP_ADD, $urandom(), LEN_W'($urandom_range(33, 63)),
                      PORT_W'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
  endtask

  function automatic int unsigned send_idle_pct();
    if (sent * 5 < total_reqs * 2) return 32;
    if (sent * 5 < total_reqs * 4) return 86;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (sent * 5 < total_reqs * 2) return 86;
    if (sent * 5 < total_reqs * 4) return 32;
    return 0;
  endfunction

  // Request driver and response back-pressure, both updated on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      if (!req_bus.valid || req_fire) begin
        if (request_q.size() != 0 && !(request_q[0].drain && answer_q.size() != 0) &&
            $urandom_range(0, 99) >= send_idle_pct()) begin
          cur_req = request_q.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.op <= cur_req.op;
          req_bus.addr <= cur_req.addr;
          req_bus.prefix_len <= cur_req.len;
          req_bus.port_in <= cur_req.port;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on each accepted request, checks each accepted response.
  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_bus.valid && req_bus.ready;
      if (req_bus.valid && req_bus.ready) begin
        seen_req.op = req_bus.op;
        seen_req.addr = req_bus.addr;
        seen_req.len = req_bus.prefix_len;
        seen_req.port = req_bus.port_in;
        seen_req.drain = 1'b0;
        answer_q.push_back(fib_apply(seen_req));
        sent++;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("response with no request outstanding, status",
                          32'(rsp_bus.status), 0);
        end else begin
          want = answer_q.pop_front();
          if (rsp_bus.status !== want.status)
            report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
          if (rsp_bus.found !== want.found)
            report_mismatch("found", 32'(rsp_bus.found), 32'(want.found));
          if (rsp_bus.out_port !== want.port)
            report_mismatch("out_port", 32'(rsp_bus.out_port), 32'(want.port));
        end
        rsp_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.op = OP_ADD;
    req_bus.addr = '0;
    req_bus.prefix_len = '0;
    req_bus.port_in = '0;
    rsp_bus.ready = 1'b0;

    queue_req(OP_LOOKUP, 32'h0A010203, 6'd0, 8'h00, 1'b0);
    queue_req(OP_ADD, 32'h12345678, 6'd0, 8'h07, 1'b0);
    queue_req(OP_ADD, 32'h0A0F0F0F, 6'd8, 8'h01, 1'b0);
    queue_req(OP_ADD, 32'h0A010000, 6'd16, 8'h02, 1'b0);
    queue_req(OP_ADD, 32'h0A010203, 6'd32, 8'hFF, 1'b0);
    queue_req(OP_ADD, 32'h0A01ABCD, 6'd16, 8'h03, 1'b0);
    queue_req(OP_ADD, 32'hC0A8014D, 6'd24, 8'h00, 1'b0);
    queue_req(OP_ADD, 32'h0A000000, 6'd33, 8'h09, 1'b0);
    queue_req(OP_ADD, 32'hFFFFFFFF, 6'd63, 8'hFF, 1'b0);
    queue_req(OP_UNUSED, 32'hFFFFFFFF, 6'd63, 8'hFF, 1'b0);
    queue_req(OP_LOOKUP, 32'h0A010203, 6'd0, 8'h00, 1'b0);
    queue_req(OP_LOOKUP, 32'h0A010909, 6'd63, 8'hFF, 1'b0);
    queue_req(OP_LOOKUP, 32'h0AC80001, 6'd0, 8'h00, 1'b0);
    queue_req(OP_LOOKUP, 32'hC0A80101, 6'd0, 8'h00, 1'b0);
    queue_req(OP_LOOKUP, 32'hFFFFFFFF, 6'd0, 8'h00, 1'b0);
    queue_req(OP_LOOKUP, 32'h00000000, 6'd0, 8'h00, 1'b0);
    queue_req(OP_CLEAR, 32'hFFFFFFFF, 6'd63, 8'hFF, 1'b0);
    // The sender holds this request back until every response so far is in.
    queue_req(OP_LOOKUP, 32'h0A010203, 6'd0, 8'h00, 1'b1);
    queue_req(OP_ADD, 32'hFFFFFFFF, 6'd32, 8'h80, 1'b0);
    queue_req(OP_LOOKUP, 32'hFFFFFFFF, 6'd0, 8'h00, 1'b0);
    queue_req(OP_LOOKUP, 32'hFFFFFFFE, 6'd0, 8'h00, 1'b0);
    build_random_traffic();
    total_reqs = request_q.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (sent != total_reqs) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* ipv4_longest_prefix_match_table.f */
+incdir+rtl
rtl/lpm_pkg.sv
rtl/lpm_req_if.sv
rtl/lpm_rsp_if.sv
rtl/lpm_ram.sv
rtl/lpm_match.sv
rtl/lpm_ctrl.sv
rtl/ipv4_longest_prefix_match_table.sv
tb/sv/tb_ipv4_longest_prefix_match_table.sv
